// ===== hw/rtl/double_ended_queue_macros.svh =====
// Assertion macros shared by the double-ended queue RTL.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define DEQ_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define DEQ_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/deq_pkg.sv =====
// Shared codes, field widths and types of the double-ended queue.
`default_nettype none

package deq_pkg;

    localparam int DATA_W   = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam cmd_t CMD_PUSH_FRONT = 2'd0;
    localparam cmd_t CMD_POP_FRONT  = 2'd1;
    localparam cmd_t CMD_PUSH_REAR  = 2'd2;
    localparam cmd_t CMD_POP_REAR   = 2'd3;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_EMPTY = 2'd1;
    localparam status_t STATUS_FULL  = 2'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/deq_ram.sv =====
// Single-port entry memory with a registered read port.
`default_nettype none

module deq_ram
    import deq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [DATA_W-1:0]        wr_data,
    output logic      [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
    end

    // Read data is held until the next read so a stalled consumer sees it stay put.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/double_ended_queue.sv =====
// Top level of the double-ended queue: pointer control, read stage and output register.
//
// Usage:
//   Requests arrive on the s_ stream. s_tuser carries the command (push front,
//   pop front, push rear, pop rear) and s_tdata the 32-bit signed value, which
//   pops ignore. Every request yields exactly one result on the m_ stream:
//   m_tdata holds the popped value (zero otherwise) and the occupancy after the
//   operation, m_tuser holds the status (ok, empty, or full).
//   Throughput is one request per cycle while m_tready is held high. The
//   accepting edge loads the read stage and the registered read port of
//   the single-port entry memory, and m_tvalid rises as the read stage advances.
//   A push into a full queue reports full and stores nothing; a pop from an
//   empty queue reports empty and returns zero. Pointer and count updates take
//   effect at the accepting edge, so back-to-back requests always see the
//   state left by the request before them.
//   Reset (aresetn low, synchronous) empties the queue and drops any result in
//   flight; the entry memory itself is not cleared since no entry is read
//   before it is written. When the receiver holds m_tready low, the output
//   register and then the read stage fill, after which s_tready drops.
`default_nettype none

module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Request stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    input  wire logic [1:0]  s_tuser,   // [1:0] cmd
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,   // [31:0] data, [36:32] occupancy, [39:37] zero
    output logic      [1:0]  m_tuser    // [1:0] status
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W:0]   DEPTH_SUM = (CNT_W + 1)'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);

    // Ring pointers: front entry index and number of stored entries.
    logic [IDX_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Read stage: request accepted, memory read under way.
    logic             p_valid_reg, p_valid_next;
    logic             p_pop_reg;
    status_t          p_status_reg;
    logic [CNT_W-1:0] p_count_reg;

    // Output register.
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_data_reg;
    status_t           m_status_reg;
    logic [OCC_W-1:0]  m_occ_reg;

    logic              accept;
    logic              out_ready;
    logic              p_advance;
    cmd_t              cmd;
    logic              is_full;
    logic              is_empty;
    logic [IDX_W-1:0]  front_dec;
    logic [IDX_W-1:0]  front_inc;
    logic [CNT_W:0]    tail_sum;
    logic [CNT_W:0]    rear_sum;
    logic [CNT_W:0]    tail_wrap;
    logic [CNT_W:0]    rear_wrap;
    logic              ram_wr;
    logic              ram_rd;
    logic [IDX_W-1:0]  ram_addr;
    logic [DATA_W-1:0] ram_rdata;
    logic              pop_ok;
    status_t           status_now;
    logic [CNT_W+4:0]  occ_ext;

    // Handshake: the read stage moves on whenever the output register is free or draining.
    assign out_ready = !m_valid_reg || m_tready;
    assign p_advance = p_valid_reg && out_ready;
    assign s_tready  = !p_valid_reg || out_ready;
    assign accept    = s_tvalid && s_tready;
    assign cmd       = s_tuser;

    assign is_full  = (count_reg == DEPTH_CNT);
    assign is_empty = (count_reg == '0);

    // Ring index arithmetic; every sum stays below twice DEPTH, so one subtract wraps it.
    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - 1'b1;
    assign front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + 1'b1;
    assign tail_sum  = (CNT_W + 1)'(front_reg) + (CNT_W + 1)'(count_reg);
    assign rear_sum  = tail_sum - 1'b1;
    assign tail_wrap = (tail_sum >= DEPTH_SUM) ? tail_sum - DEPTH_SUM : tail_sum;
    assign rear_wrap = (rear_sum >= DEPTH_SUM) ? rear_sum - DEPTH_SUM : rear_sum;

    // Command decode: pick the memory access and the new pointers.
    always_comb begin
        front_next = front_reg;
        count_next = count_reg;
        ram_wr     = 1'b0;
        ram_rd     = 1'b0;
        ram_addr   = front_reg;
        pop_ok     = 1'b0;
        status_now = STATUS_OK;
        case (cmd)
            CMD_PUSH_FRONT: begin
                if (is_full) begin
                    status_now = STATUS_FULL;
                end else begin
                    ram_wr     = accept;
                    ram_addr   = front_dec;
                    front_next = front_dec;
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_POP_FRONT: begin
                if (is_empty) begin
                    status_now = STATUS_EMPTY;
                end else begin
                    ram_rd     = accept;
                    pop_ok     = 1'b1;
                    ram_addr   = front_reg;
                    front_next = front_inc;
                    count_next = count_reg - 1'b1;
                end
            end
            CMD_PUSH_REAR: begin
                if (is_full) begin
                    status_now = STATUS_FULL;
                end else begin
                    ram_wr     = accept;
                    ram_addr   = tail_wrap[IDX_W-1:0];
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_POP_REAR: begin
                if (is_empty) begin
                    status_now = STATUS_EMPTY;
                end else begin
                    ram_rd     = accept;
                    pop_ok     = 1'b1;
                    ram_addr   = rear_wrap[IDX_W-1:0];
                    count_next = count_reg - 1'b1;
                end
            end
            default: begin
                status_now = STATUS_OK;
            end
        endcase
    end

    // A write lands at the accepting edge, so a read by the next request already sees it.
    deq_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr),
        .rd_en   (ram_rd),
        .addr    (ram_addr),
        .wr_data (s_tdata),
        .rd_data (ram_rdata)
    );

    always_comb begin
        p_valid_next = p_valid_reg;
        if (accept) begin
            p_valid_next = 1'b1;
        end else if (p_advance) begin
            p_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (p_advance) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg   <= '0;
            count_reg   <= '0;
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= p_valid_next;
            m_valid_reg <= m_valid_next;
            if (accept) begin
                front_reg <= front_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p_pop_reg    <= pop_ok;
            p_status_reg <= status_now;
            p_count_reg  <= count_next;
        end
    end

    // Occupancy is reported modulo 32.
    assign occ_ext = (CNT_W + 5)'(p_count_reg);

    always_ff @(posedge aclk) begin
        if (p_advance) begin
            m_data_reg   <= p_pop_reg ? ram_rdata : '0;
            m_status_reg <= p_status_reg;
            m_occ_reg    <= occ_ext[OCC_W-1:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_occ_reg, m_data_reg};
    assign m_tuser  = m_status_reg;

    `include "double_ended_queue_macros.svh"

    // The count never runs past the ring size.
    `DEQ_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= DEPTH_CNT,
        "entry count exceeds DEPTH")

    // A refused push leaves the pointers untouched.
    `DEQ_ASSERT_NXT(a_full_holds, aclk, aresetn,
        accept && (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_REAR) && is_full,
        $stable(count_reg) && $stable(front_reg), "push into full queue moved pointers")

    // A result that reports empty carries zero data.
    `DEQ_ASSERT_IMP(a_empty_zero, aclk, aresetn,
        m_valid_reg && m_status_reg == STATUS_EMPTY, m_data_reg == '0,
        "empty result carries nonzero data")

    // The read stage never holds a result while the output register is free to take it.
    `DEQ_ASSERT_NXT(a_stage_drains, aclk, aresetn,
        p_valid_reg && !m_valid_reg && !accept, !p_valid_reg && m_valid_reg,
        "read stage failed to drain into free output register")

endmodule

`default_nettype wire
